// ===== rtl/core/led_button_flash_and_report_macros.svh =====
// ----------------------------------------------------------------------------
// LED button assertion macros
// Shared concurrent assertion forms for the LED button block.
// ----------------------------------------------------------------------------
`ifndef LED_BUTTON_FLASH_AND_REPORT_MACROS_SVH
`define LED_BUTTON_FLASH_AND_REPORT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LBFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbfr assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LBFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbfr assertion failed");

`endif

// ===== rtl/core/lbfr_pkg.sv =====
// ----------------------------------------------------------------------------
// LED button package
// Types, constants and arithmetic helpers shared by the LED button block.
// ----------------------------------------------------------------------------
package lbfr_pkg;

    localparam int TIME_BITS = 32;

    typedef logic [TIME_BITS-1:0] time_t;

    // Input commands
    typedef enum logic [1:0] {
        CMD_SET_COLOR   = 2'd0,
        CMD_START_FLASH = 2'd1,
        CMD_TIME_TICK   = 2'd2
    } cmd_t;

    // Result kinds
    typedef enum logic {
        KIND_PIXEL  = 1'b0,
        KIND_REPORT = 1'b1
    } kind_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_RED_ID         = 3'd0;
    localparam logic [2:0] CFG_GREEN_ID       = 3'd1;
    localparam logic [2:0] CFG_BLUE_ID        = 3'd2;
    localparam logic [2:0] CFG_PIXEL_INDEX    = 3'd3;
    localparam logic [2:0] CFG_FLASH_INTERVAL = 3'd4;
    localparam logic [2:0] CFG_REPORT_HOLDOFF = 3'd5;

    localparam logic [15:0] FLASH_INTERVAL_RESET = 16'd200;
    localparam logic [15:0] REPORT_HOLDOFF_RESET = 16'd500;

    localparam logic [6:0]  LEVEL_MAX       = 7'd100;
    localparam logic [2:0]  FLASH_LAST_STEP = 3'd3;
    // 2^19 / 100, rounded up; exact for every product up to 100*255
    localparam logic [26:0] SCALE_RECIP     = 27'd5243;

    typedef struct packed {
        logic [9:0]  red_id;
        logic [9:0]  green_id;
        logic [9:0]  blue_id;
        logic [7:0]  pixel_index;
        logic [15:0] flash_interval;
        logic [15:0] report_holdoff;
    } cfg_t;

    // One input's results, handed from the core to the output stage
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] position;
        logic [2:0] mask;       // channels to report: bit 0 red, 1 green, 2 blue
        logic [6:0] lvl_red;
        logic [6:0] lvl_green;
        logic [6:0] lvl_blue;
    } bundle_t;

    function automatic logic [6:0] sat_level(input logic [6:0] v);
        return (v > LEVEL_MAX) ? LEVEL_MAX : v;
    endfunction

    // pct * 255 / 100, truncated
    function automatic logic [7:0] scale_level(input logic [6:0] pct);
        logic [14:0] p;
        logic [26:0] prod;
        p    = {pct, 8'b0} - {8'b0, pct};
        prod = 27'(p) * SCALE_RECIP;
        return prod[26:19];
    endfunction

    function automatic logic past_deadline(input time_t now, input time_t last,
                                           input logic [15:0] delay);
        time_t deadline;
        deadline = last + TIME_BITS'(delay);
        return now > deadline;
    endfunction

endpackage

// ===== rtl/core/lbfr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// LED button configuration registers
// Write-only register file for channel ids, pixel position and timing.
// ----------------------------------------------------------------------------
module lbfr_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [15:0]     cfg_data,
    output lbfr_pkg::cfg_t  cfg
);

    lbfr_pkg::cfg_t cfg_reg;
    lbfr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                lbfr_pkg::CFG_RED_ID:         cfg_next.red_id         = cfg_data[9:0];
                lbfr_pkg::CFG_GREEN_ID:       cfg_next.green_id       = cfg_data[9:0];
                lbfr_pkg::CFG_BLUE_ID:        cfg_next.blue_id        = cfg_data[9:0];
                lbfr_pkg::CFG_PIXEL_INDEX:    cfg_next.pixel_index    = cfg_data[7:0];
                lbfr_pkg::CFG_FLASH_INTERVAL: cfg_next.flash_interval = cfg_data;
                lbfr_pkg::CFG_REPORT_HOLDOFF: cfg_next.report_holdoff = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red_id         <= '0;
            cfg_reg.green_id       <= '0;
            cfg_reg.blue_id        <= '0;
            cfg_reg.pixel_index    <= '0;
            cfg_reg.flash_interval <= lbfr_pkg::FLASH_INTERVAL_RESET;
            cfg_reg.report_holdoff <= lbfr_pkg::REPORT_HOLDOFF_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/lbfr_core.sv =====
// ----------------------------------------------------------------------------
// LED button command core
// Input register, button state and the single-pass command decode.
// ----------------------------------------------------------------------------
`include "led_button_flash_and_report_macros.svh"

module lbfr_core (
    input  logic                clk,
    input  logic                rst_n,
    input  lbfr_pkg::cfg_t      cfg,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          s_cmd,
    input  logic [6:0]          s_red,
    input  logic [6:0]          s_green,
    input  logic [6:0]          s_blue,
    input  logic [31:0]         s_now,
    input  logic                out_free,
    output lbfr_pkg::bundle_t   bundle
);

    // Input register
    logic                   in_valid_reg;
    logic [1:0]             in_cmd_reg;
    logic [6:0]             in_red_reg;
    logic [6:0]             in_green_reg;
    logic [6:0]             in_blue_reg;
    lbfr_pkg::time_t        in_now_reg;

    // Button state
    logic [6:0]             level_red_reg,   level_red_next;
    logic [6:0]             level_green_reg, level_green_next;
    logic [6:0]             level_blue_reg,  level_blue_next;
    logic [2:0]             pending_reg,     pending_next;
    logic                   flash_active_reg, flash_active_next;
    logic [2:0]             flash_count_reg, flash_count_next;
    logic                   flash_phase_reg, flash_phase_next;
    lbfr_pkg::time_t        last_event_reg,  last_event_next;

    logic                   advance;
    logic                   in_take;
    logic [6:0]             sat_red, sat_green, sat_blue;
    logic [6:0]             src_red, src_green, src_blue;
    logic                   flash_due;
    logic                   report_due;
    logic                   is_set;
    lbfr_pkg::bundle_t      bundle_c;

    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg   <= s_cmd;
            in_red_reg   <= s_red;
            in_green_reg <= s_green;
            in_blue_reg  <= s_blue;
            in_now_reg   <= lbfr_pkg::time_t'(s_now);
        end
    end

    assign sat_red   = lbfr_pkg::sat_level(in_red_reg);
    assign sat_green = lbfr_pkg::sat_level(in_green_reg);
    assign sat_blue  = lbfr_pkg::sat_level(in_blue_reg);

    assign flash_due  = flash_active_reg
                     && lbfr_pkg::past_deadline(in_now_reg, last_event_reg, cfg.flash_interval);
    assign report_due = !flash_due && (pending_reg != 3'b000)
                     && lbfr_pkg::past_deadline(in_now_reg, last_event_reg, cfg.report_holdoff);

    // One scaler per channel: new levels on set color, stored ones on a restore
    assign is_set   = (in_cmd_reg == lbfr_pkg::CMD_SET_COLOR);
    assign src_red   = is_set ? sat_red   : level_red_reg;
    assign src_green = is_set ? sat_green : level_green_reg;
    assign src_blue  = is_set ? sat_blue  : level_blue_reg;

    always_comb
    begin
        level_red_next    = level_red_reg;
        level_green_next  = level_green_reg;
        level_blue_next   = level_blue_reg;
        pending_next      = pending_reg;
        flash_active_next = flash_active_reg;
        flash_count_next  = flash_count_reg;
        flash_phase_next  = flash_phase_reg;
        last_event_next   = last_event_reg;

        bundle_c.valid     = 1'b0;
        bundle_c.kind      = lbfr_pkg::KIND_PIXEL;
        bundle_c.red       = lbfr_pkg::scale_level(src_red);
        bundle_c.green     = lbfr_pkg::scale_level(src_green);
        bundle_c.blue      = lbfr_pkg::scale_level(src_blue);
        bundle_c.position  = cfg.pixel_index;
        bundle_c.mask      = pending_reg;
        bundle_c.lvl_red   = level_red_reg;
        bundle_c.lvl_green = level_green_reg;
        bundle_c.lvl_blue  = level_blue_reg;

        case (in_cmd_reg)
            lbfr_pkg::CMD_SET_COLOR:
            begin
                level_red_next   = sat_red;
                level_green_next = sat_green;
                level_blue_next  = sat_blue;
                pending_next     = pending_reg | {sat_blue  != level_blue_reg,
                                                  sat_green != level_green_reg,
                                                  sat_red   != level_red_reg};
                bundle_c.valid   = 1'b1;
            end
            lbfr_pkg::CMD_START_FLASH:
            begin
                flash_count_next  = 3'd0;
                flash_active_next = 1'b1;
                flash_phase_next  = 1'b0;
            end
            lbfr_pkg::CMD_TIME_TICK:
            begin
                if (flash_due)
                begin
                    last_event_next  = in_now_reg;
                    flash_phase_next = !flash_phase_reg;
                    flash_count_next = flash_count_reg + 3'd1;
                    if (flash_count_reg == lbfr_pkg::FLASH_LAST_STEP)
                    begin
                        flash_active_next = 1'b0;
                    end
                    bundle_c.valid = 1'b1;
                    // Dark phase: write black
                    if (!flash_phase_reg)
                    begin
                        bundle_c.red   = 8'd0;
                        bundle_c.green = 8'd0;
                        bundle_c.blue  = 8'd0;
                    end
                end
                else if (report_due)
                begin
                    last_event_next = in_now_reg;
                    pending_next    = 3'b000;
                    bundle_c.valid  = 1'b1;
                    bundle_c.kind   = lbfr_pkg::KIND_REPORT;
                end
            end
            default:
            begin
                bundle_c.valid = 1'b0;
            end
        endcase

        if (!advance)
        begin
            bundle_c.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_red_reg    <= '0;
            level_green_reg  <= '0;
            level_blue_reg   <= '0;
            pending_reg      <= '0;
            flash_active_reg <= 1'b0;
            flash_count_reg  <= '0;
            flash_phase_reg  <= 1'b0;
            last_event_reg   <= '0;
        end
        else if (advance)
        begin
            level_red_reg    <= level_red_next;
            level_green_reg  <= level_green_next;
            level_blue_reg   <= level_blue_next;
            pending_reg      <= pending_next;
            flash_active_reg <= flash_active_next;
            flash_count_reg  <= flash_count_next;
            flash_phase_reg  <= flash_phase_next;
            last_event_reg   <= last_event_next;
        end
    end

    assign bundle = bundle_c;

    `LBFR_ASSERT_NOW(a_flash_count_range, clk, rst_n, flash_active_reg,
                     flash_count_reg <= lbfr_pkg::FLASH_LAST_STEP)
    `LBFR_ASSERT_NOW(a_levels_saturated, clk, rst_n, 1'b1,
                     (level_red_reg <= lbfr_pkg::LEVEL_MAX)
                     && (level_green_reg <= lbfr_pkg::LEVEL_MAX)
                     && (level_blue_reg <= lbfr_pkg::LEVEL_MAX))

endmodule

// ===== rtl/core/lbfr_out_stage.sv =====
// ----------------------------------------------------------------------------
// LED button output stage
// Holds one input's results and sends them out one transaction at a time.
// ----------------------------------------------------------------------------
`include "led_button_flash_and_report_macros.svh"

module lbfr_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  lbfr_pkg::cfg_t      cfg,
    input  lbfr_pkg::bundle_t   bundle,
    output logic                out_free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [55:0]         m_tdata,
    output logic                m_tlast,
    output logic                m_tuser
);

    logic                   out_valid_reg;
    lbfr_pkg::bundle_t      hold_reg;
    logic [2:0]             mask_reg;
    logic [2:0]             mask_rest;
    logic                   sel_red;
    logic                   sel_green;
    logic                   is_report;
    logic                   xfer;
    logic                   finishing;
    logic [9:0]             report_id;
    logic [6:0]             report_level;
    logic [7:0]             px_red, px_green, px_blue, px_pos;

    assign is_report = (hold_reg.kind == lbfr_pkg::KIND_REPORT);
    assign mask_rest = mask_reg & (mask_reg - 3'd1);
    assign sel_red   = mask_reg[0];
    assign sel_green = !mask_reg[0] && mask_reg[1];

    assign m_tvalid  = out_valid_reg;
    assign m_tlast   = !is_report || (mask_rest == 3'b000);
    assign m_tuser   = hold_reg.kind;
    assign xfer      = out_valid_reg && m_tready;
    assign finishing = xfer && m_tlast;
    assign out_free  = !out_valid_reg || finishing;

    always_comb
    begin
        report_id    = 10'd0;
        report_level = 7'd0;
        px_red       = 8'd0;
        px_green     = 8'd0;
        px_blue      = 8'd0;
        px_pos       = 8'd0;
        if (is_report)
        begin
            if (sel_red)
            begin
                report_id    = cfg.red_id;
                report_level = hold_reg.lvl_red;
            end
            else if (sel_green)
            begin
                report_id    = cfg.green_id;
                report_level = hold_reg.lvl_green;
            end
            else
            begin
                report_id    = cfg.blue_id;
                report_level = hold_reg.lvl_blue;
            end
        end
        else
        begin
            px_red   = hold_reg.red;
            px_green = hold_reg.green;
            px_blue  = hold_reg.blue;
            px_pos   = hold_reg.position;
        end
    end

    assign m_tdata = {7'd0, report_level, report_id, px_pos, px_blue, px_green, px_red};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (bundle.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (finishing)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bundle.valid)
        begin
            hold_reg <= bundle;
            mask_reg <= bundle.mask;
        end
        else if (xfer)
        begin
            // drop the channel just reported
            mask_reg <= mask_rest;
        end
    end

    `LBFR_ASSERT_NOW(a_load_only_when_free, clk, rst_n, bundle.valid,
                     !out_valid_reg || finishing)
    `LBFR_ASSERT_NOW(a_report_has_channel, clk, rst_n, out_valid_reg && is_report,
                     mask_reg != 3'b000)
    `LBFR_ASSERT_NEXT(a_more_reports_follow, clk, rst_n, xfer && !m_tlast,
                      out_valid_reg)

endmodule

// ===== rtl/core/led_button_flash_and_report.sv =====
// ----------------------------------------------------------------------------
// LED button flash and report
// Drives one RGB LED button pixel, flashes it and reports level changes.
// ----------------------------------------------------------------------------
//  Channel  | Signals                         | Contents
//  ---------+---------------------------------+----------------------------------
//  input    | s_tvalid s_tready s_tdata s_tuser | one command per transaction
//  output   | m_tvalid m_tready m_tdata m_tuser m_tlast | pixel write or report
//  config   | cfg_we cfg_index cfg_data       | register write, no read-back
//
//  A command waits in the input register until the output register is free,
//  then its first result is registered there; one transaction per cycle while
//  m_tready stays high. A report tick gives one output transaction per changed
//  channel (one to three), which the output stage emits one at a time.
//  The input register can still take a transaction while the output register
//  holds a result; it stalls only when both are full.
//  Reset clears all button state and loads the register defaults.
// ----------------------------------------------------------------------------
module led_button_flash_and_report (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // red_level[6:0], green_level[13:7], blue_level[20:14],
                                   // now_ms[52:21], zero[55:53]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16],
                                   // pixel_position[31:24], report_id[41:32],
                                   // report_level[48:42], zero[55:49]
    output logic        m_tuser,   // kind[0]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    lbfr_pkg::cfg_t     cfg;
    lbfr_pkg::bundle_t  bundle;
    logic               out_free;

    lbfr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lbfr_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .s_red    (s_tdata[6:0]),
        .s_green  (s_tdata[13:7]),
        .s_blue   (s_tdata[20:14]),
        .s_now    (s_tdata[52:21]),
        .out_free (out_free),
        .bundle   (bundle)
    );

    lbfr_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .bundle   (bundle),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
